[design/dra_pkg.sv]
// dra_pkg: shared types and constants for the detector response accumulator
// holds opcodes, register indexes, reset values, the controller state type and the
// command and status structs. No dependencies.
package dra_pkg;

  // stream payload widths
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 56;

  // request opcodes carried in in_tuser
  localparam logic [1:0] OP_LOAD_PROFILE = 2'd0;
  localparam logic [1:0] OP_LOAD_WEIGHT  = 2'd1;
  localparam logic [1:0] OP_COMPUTE      = 2'd2;

  // configuration register indexes
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_BEAM_START      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BEAM_STEP       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BIN_OFFSET      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_VOXEL      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PROFILE_SCALE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BEAM_SAMPLES    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_PROFILE_ENTRIES = 3'd6;

  // register reset values
  localparam logic [30:0] HALF_VOXEL_RST      = 31'd65536;
  localparam logic [8:0]  BEAM_SAMPLES_RST    = 9'd256;
  localparam logic [8:0]  PROFILE_ENTRIES_RST = 9'd256;

  // configuration register file contents
  typedef struct packed {
    logic signed [31:0] beam_start;
    logic [30:0]        beam_step;
    logic signed [31:0] bin_offset;
    logic [30:0]        half_voxel_width;
    logic [31:0]        profile_scale;
    logic [8:0]         beam_samples;
    logic [8:0]         profile_entries;
  } cfg_t;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } ctrl_state_t;

  // controller to datapath commands
  typedef struct packed {
    logic load_profile;
    logic load_weight;
    logic start;
    logic issue;
    logic publish;
  } ctrl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic nsamp_zero;
    logic last_issue;
    logic pipe_busy;
    logic out_free;
  } dp_status_t;

endpackage

[design/dra_ram.sv]
// dra_ram: generic single write port, single read port memory with registered read
// no dependencies
module dra_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                                    clk,
  input  logic                                    wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                        wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                        rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

[design/dra_cfg.sv]
// dra_cfg: configuration register file written through the plain write port
// depends on dra_pkg
module dra_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [dra_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dra_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output dra_pkg::cfg_t                  cfg
);

  dra_pkg::cfg_t cfg_r;

  // register writes, unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.beam_start       <= '0;
      cfg_r.beam_step        <= '0;
      cfg_r.bin_offset       <= '0;
      cfg_r.half_voxel_width <= dra_pkg::HALF_VOXEL_RST;
      cfg_r.profile_scale    <= '0;
      cfg_r.beam_samples     <= dra_pkg::BEAM_SAMPLES_RST;
      cfg_r.profile_entries  <= dra_pkg::PROFILE_ENTRIES_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dra_pkg::CFG_BEAM_START:      cfg_r.beam_start       <= cfg_wdata;
        dra_pkg::CFG_BEAM_STEP:       cfg_r.beam_step        <= cfg_wdata[30:0];
        dra_pkg::CFG_BIN_OFFSET:      cfg_r.bin_offset       <= cfg_wdata;
        dra_pkg::CFG_HALF_VOXEL:      cfg_r.half_voxel_width <= cfg_wdata[30:0];
        dra_pkg::CFG_PROFILE_SCALE:   cfg_r.profile_scale    <= cfg_wdata;
        dra_pkg::CFG_BEAM_SAMPLES:    cfg_r.beam_samples     <= cfg_wdata[8:0];
        dra_pkg::CFG_PROFILE_ENTRIES: cfg_r.profile_entries  <= cfg_wdata[8:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

[design/dra_ctrl.sv]
// dra_ctrl: request sequencer, accepts requests and steps the sample pipeline
// depends on dra_pkg (state type, command and status structs)
module dra_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [1:0]           in_tuser,
  input  dra_pkg::dp_status_t  stat,
  output dra_pkg::ctrl_cmd_t   cmd
);

  dra_pkg::ctrl_state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dra_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      dra_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          unique case (in_tuser)
            dra_pkg::OP_LOAD_PROFILE: cmd.load_profile = 1'b1;
            dra_pkg::OP_LOAD_WEIGHT:  cmd.load_weight  = 1'b1;
            dra_pkg::OP_COMPUTE: begin
              cmd.start = 1'b1;
              state_nxt = stat.nsamp_zero ? dra_pkg::ST_DRAIN : dra_pkg::ST_RUN;
            end
            default: ;
          endcase
        end
      end
      dra_pkg::ST_RUN: begin
        cmd.issue = 1'b1;
        if (stat.last_issue) begin
          state_nxt = dra_pkg::ST_DRAIN;
        end
      end
      dra_pkg::ST_DRAIN: begin
        if (!stat.pipe_busy && stat.out_free) begin
          cmd.publish = 1'b1;
          state_nxt   = dra_pkg::ST_IDLE;
        end
      end
      default: state_nxt = dra_pkg::ST_IDLE;
    endcase
  end

  // no request is taken while samples are still in flight
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    stat.pipe_busy |-> !in_tready)
    else $error("request accepted while sample pipeline busy");

  // the last sample is issued once
  a_last_issue_once: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.issue && stat.last_issue) |=> !cmd.issue)
    else $error("sample issued after the last one");

  // a result is published only into a free output register
  a_publish_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.publish |-> stat.out_free)
    else $error("result published over a waiting one");

endmodule

[design/dra_dp.sv]
// dra_dp: tables, sample pipeline (index scaling, lookup, multiply, accumulate)
// and the result register. depends on dra_pkg and dra_ram
module dra_dp #(
  parameter int MAX_ANGLES  = 64,
  parameter int MAX_PROFILE = 256,
  parameter int MAX_BEAM    = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  dra_pkg::cfg_t       cfg,
  input  dra_pkg::ctrl_cmd_t  cmd,
  output dra_pkg::dp_status_t stat,
  input  logic [5:0]          in_angle,
  input  logic [7:0]          in_entry_index,
  input  logic [15:0]         in_entry_value,
  input  logic [5:0]          in_detector_bin,
  input  logic                out_tready,
  output logic                out_tvalid,
  output logic [40:0]         out_response,
  output logic [5:0]          out_result_angle,
  output logic [5:0]          out_result_bin
);

  localparam int PROF_DEPTH = MAX_ANGLES * MAX_PROFILE;
  localparam int PAW  = (PROF_DEPTH > 1) ? $clog2(PROF_DEPTH) : 1;
  localparam int BAW  = (MAX_BEAM > 1) ? $clog2(MAX_BEAM) : 1;
  localparam int PIW  = $clog2(MAX_PROFILE);
  localparam int NMAX = (MAX_BEAM < 511) ? MAX_BEAM : 511;
  localparam int CW   = $clog2(NMAX + 1);

  // per-item registers
  logic [CW-1:0]      p_r, nsamp_r;
  logic signed [41:0] r_r;
  logic signed [38:0] rmin_r;
  logic [PIW-1:0]     lim_r;
  logic [PAW-1:0]     base_r;
  logic               angle_ok_r;
  logic [5:0]         res_angle_r, res_bin_r;
  logic [40:0]        sum_r;

  // pipeline registers
  logic               va_r, vb_r, vc_r, vd_r, ve_r;
  logic [41:0]        a_diff_r;
  logic               a_skip_r, b_skip_r, c_skip_r, d_skip_r;
  logic [CW-1:0]      a_p_r, b_p_r, c_p_r;
  logic [57:0]        b_hi_r;
  logic [47:0]        b_lo_r;
  logic [PIW-1:0]     c_pi_r;
  logic [31:0]        e_prod_r;

  // result register
  logic               out_valid_r;
  logic [40:0]        out_resp_r;
  logic [5:0]         out_angle_r, out_bin_r;

  // combinational
  logic [CW-1:0]      nsamp_nxt;
  logic [31:0]        ent_w;
  logic [PIW-1:0]     lim_nxt;
  logic signed [38:0] bin_s, off_s, hv_s, rmin_nxt;
  logic signed [42:0] diff_w;
  logic [58:0]        pi_sum;
  logic [42:0]        pi_full;
  logic [PIW-1:0]     pi_clamp;
  logic [31:0]        mul_w;
  logic               prof_we, wt_we;
  logic [PAW-1:0]     prof_waddr, prof_raddr;
  logic [BAW-1:0]     wt_waddr, wt_raddr;
  logic [15:0]        prof_rdata, wt_rdata;

  // per-item limits and the bin threshold
  always_comb begin
    nsamp_nxt = (32'(cfg.beam_samples) > NMAX) ? CW'(NMAX) : CW'(cfg.beam_samples);
    ent_w     = (32'(cfg.profile_entries) > MAX_PROFILE) ? 32'(MAX_PROFILE)
                                                         : 32'(cfg.profile_entries);
    if (ent_w == 32'd0) begin
      ent_w = 32'd1;
    end
    lim_nxt  = PIW'(ent_w - 32'd1);
    bin_s    = 39'(in_detector_bin);
    off_s    = 39'(cfg.bin_offset);
    hv_s     = 39'(cfg.half_voxel_width);
    rmin_nxt = bin_s * off_s - hv_s;
  end

  // table loads
  assign prof_we    = cmd.load_profile && (32'(in_angle) < MAX_ANGLES)
                      && (32'(in_entry_index) < MAX_PROFILE);
  assign prof_waddr = PAW'(32'(in_angle) * 32'(MAX_PROFILE) + 32'(in_entry_index));
  assign wt_we      = cmd.load_weight && (32'(in_entry_index) < MAX_BEAM);
  assign wt_waddr   = BAW'(in_entry_index);

  // stage a: distance from the bin threshold
  assign diff_w = 43'(r_r) - 43'(rmin_r);

  // stage c: integer part of the scaled distance, clamped to the profile limit
  always_comb begin
    pi_sum   = 59'(b_hi_r) + 59'(b_lo_r[47:16]);
    pi_full  = pi_sum[58:16];
    pi_clamp = (pi_full > 43'(lim_r)) ? lim_r : pi_full[PIW-1:0];
  end

  // stage d: table lookups
  assign prof_raddr = base_r + PAW'(c_pi_r);
  assign wt_raddr   = BAW'(c_p_r);

  // stage e: weighted profile value
  assign mul_w = 32'(prof_rdata) * 32'(wt_rdata);

  dra_ram #(.WIDTH(16), .DEPTH(PROF_DEPTH)) u_profile_ram (
    .clk     (clk),
    .wr_en   (prof_we),
    .wr_addr (prof_waddr),
    .wr_data (in_entry_value),
    .rd_addr (prof_raddr),
    .rd_data (prof_rdata)
  );

  dra_ram #(.WIDTH(16), .DEPTH(MAX_BEAM)) u_weight_ram (
    .clk     (clk),
    .wr_en   (wt_we),
    .wr_addr (wt_waddr),
    .wr_data (in_entry_value),
    .rd_addr (wt_raddr),
    .rd_data (wt_rdata)
  );

  // item setup and sample walk
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      p_r         <= '0;
      nsamp_r     <= nsamp_nxt;
      r_r         <= 42'(cfg.beam_start);
      rmin_r      <= rmin_nxt;
      lim_r       <= lim_nxt;
      base_r      <= PAW'(32'(in_angle) * 32'(MAX_PROFILE));
      angle_ok_r  <= 32'(in_angle) < MAX_ANGLES;
      res_angle_r <= in_angle;
      res_bin_r   <= in_detector_bin;
    end else if (cmd.issue) begin
      p_r <= p_r + CW'(1);
      r_r <= r_r + 42'(cfg.beam_step);
    end
  end

  // pipeline valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
      ve_r <= 1'b0;
    end else begin
      va_r <= cmd.issue;
      vb_r <= va_r;
      vc_r <= vb_r;
      vd_r <= vc_r;
      ve_r <= vd_r;
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    a_diff_r <= diff_w[41:0];
    a_skip_r <= diff_w[42];
    a_p_r    <= p_r;
    b_hi_r   <= 58'(a_diff_r[41:16]) * 58'(cfg.profile_scale);
    b_lo_r   <= 48'(a_diff_r[15:0]) * 48'(cfg.profile_scale);
    b_skip_r <= a_skip_r;
    b_p_r    <= a_p_r;
    c_pi_r   <= pi_clamp;
    c_skip_r <= b_skip_r;
    c_p_r    <= b_p_r;
    d_skip_r <= c_skip_r;
    e_prod_r <= (d_skip_r || !angle_ok_r) ? 32'd0 : mul_w;
  end

  // accumulator, wraps at 41 bits
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      sum_r <= '0;
    end else if (ve_r) begin
      sum_r <= sum_r + 41'(e_prod_r);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.publish) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      out_resp_r  <= sum_r;
      out_angle_r <= res_angle_r;
      out_bin_r   <= res_bin_r;
    end
  end

  // status to the controller
  assign stat.nsamp_zero = (cfg.beam_samples == 9'd0);
  assign stat.last_issue = (p_r == (nsamp_r - CW'(1)));
  assign stat.pipe_busy  = va_r | vb_r | vc_r | vd_r | ve_r;
  assign stat.out_free   = !out_valid_r || out_tready;

  assign out_tvalid       = out_valid_r;
  assign out_response     = out_resp_r;
  assign out_result_angle = out_angle_r;
  assign out_result_bin   = out_bin_r;

  // samples in flight stay below the item's sample count
  a_sample_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    va_r |-> (a_p_r < nsamp_r))
    else $error("sample index beyond sample count");

  // a new item starts on an empty pipeline
  a_start_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |-> !stat.pipe_busy)
    else $error("item started with samples in flight");

  // a result appears only through a publish
  a_valid_from_publish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.publish))
    else $error("result valid without publish");

endmodule

[design/detector_response_accumulator_unit.sv]
// detector_response_accumulator_unit: top level, stream ports and configuration port
// depends on dra_pkg, dra_cfg, dra_ctrl, dra_dp (which holds two dra_ram instances)
//
// Load requests (profile entry or beam weight) leave the controller idle. For a compute
// request the accepting cycle sets up the item, then one beam sample a cycle, up to
// beam_samples limited to MAX_BEAM, goes through a single six-stage pipeline
// (distance, index scaling multiply, clamp, profile and weight memory read, product,
// accumulate) and a final drain, after which the result is published and the next
// request is taken. With no beam samples the item goes straight to the drain. A result
// that would replace one still waiting in the output register holds until that one is
// taken. That one sample per cycle is set by the single read port of the profile
// memory and the one multiply-accumulate unit. One request is in work at a time; a
// finished result sits in the output register, so load requests and the next compute
// are accepted while it waits to be taken. Both tables come up undefined after reset
// and need no clear.
module detector_response_accumulator_unit #(
  parameter int MAX_ANGLES  = 64,
  parameter int MAX_PROFILE = 256,
  parameter int MAX_BEAM    = 256
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // request stream
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // angle [5:0], entry_index [13:6], entry_value [29:14], detector_bin [35:30]
  input  logic [dra_pkg::IN_TDATA_W-1:0]   in_tdata,
  // opcode [1:0]
  input  logic [1:0]                       in_tuser,
  // result stream
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // response [40:0], result_angle [46:41], result_bin [52:47]
  output logic [dra_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // configuration write port
  input  logic                             cfg_we,
  input  logic [dra_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dra_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  dra_pkg::cfg_t       cfg;
  dra_pkg::ctrl_cmd_t  cmd;
  dra_pkg::dp_status_t stat;
  logic [40:0]         response;
  logic [5:0]          result_angle, result_bin;

  dra_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  dra_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .stat      (stat),
    .cmd       (cmd)
  );

  dra_dp #(
    .MAX_ANGLES  (MAX_ANGLES),
    .MAX_PROFILE (MAX_PROFILE),
    .MAX_BEAM    (MAX_BEAM)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg),
    .cmd              (cmd),
    .stat             (stat),
    .in_angle         (in_tdata[5:0]),
    .in_entry_index   (in_tdata[13:6]),
    .in_entry_value   (in_tdata[29:14]),
    .in_detector_bin  (in_tdata[35:30]),
    .out_tready       (out_tready),
    .out_tvalid       (out_tvalid),
    .out_response     (response),
    .out_result_angle (result_angle),
    .out_result_bin   (result_bin)
  );

  // pack the result, zero pad to whole bytes
  assign out_tdata = {3'b000, result_bin, result_angle, response};

endmodule
